// ----- rtl/core/msre_pkg.sv -----
// Package for the Modbus slave register engine: request kinds, item types,
// swap-map helper. No dependencies.
`default_nettype none
package msre_pkg;
    typedef enum logic [2:0] {
        K_RD_COILS = 3'd0, K_WR_COIL = 3'd1, K_COIL_ELEM = 3'd2, K_RD_INPUTS = 3'd3,
        K_RD_HOLD = 3'd4, K_WR_HOLD = 3'd5, K_HOLD_ELEM = 3'd6, K_IGNORED = 3'd7
    } t_kind;

    localparam logic [15:0] COIL_ON    = 16'hFF00;
    localparam int          INPUT_BITS = 32;
    localparam int          PIN_BITS   = 11;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  unit_address;
        logic [7:0]  source_channel;
        logic [15:0] start_register;
        logic [15:0] quantity_or_value;
        logic [6:0]  element_index;
        logic [15:0] element_data;
        logic        last_element;
        logic [10:0] pin_levels;
    } t_req;

    typedef struct packed {
        logic [7:0]  reply_channel;
        logic [15:0] reply_unit;
        logic [2:0]  reply_kind;
        logic [15:0] echo_register;
        logic [15:0] echo_quantity;
        logic [7:0]  byte_count;
        logic [15:0] data_value;
        logic [5:0]  data_index;
        logic        last_result;
        logic [7:0]  coil_drive;
    } t_rsp;

    // Swap map: words 3..13, then per block of 22 all but the first 4.
    // Only words below 256 exist; d / 22 by reciprocal multiply (exact for 8 bits).
    function automatic logic is_swapped(input logic [15:0] w);
        logic [7:0]  d;
        logic [17:0] p;
        logic [7:0]  q;
        logic [7:0]  m;
        begin
            d = w[7:0] - 8'd14;
            p = 18'(d) * 18'd745;
            q = {4'd0, p[17:14]};
            m = d - q * 8'd22;
            if (w < 16'd14) is_swapped = (w >= 16'd3);
            else            is_swapped = (w < 16'd256) && (m >= 8'd4);
        end
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/msre_if.sv -----
// Valid/ready channel interfaces for requests and replies.
// Depends on msre_pkg.
`default_nettype none
interface msre_req_if import msre_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface msre_rsp_if import msre_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/msre_front.sv -----
// Front end: accepts requests into a two-entry queue for the back end.
// Depends on msre_pkg.
`default_nettype none
module msre_front import msre_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  wire  i_take,
    output t_req o_req
);
    t_req       r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_take;
    assign o_req   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= i_req;
        if (!i_rst_n) begin
            r_rd <= 1'b0; r_wr <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/msre_back.sv -----
// Back end: executes one request, walks read replies element by element,
// holds coils and the holding-word memory. Depends on msre_pkg.
`default_nettype none
module msre_back import msre_pkg::*; #(
    parameter int HOLDING_WORDS = 168,
    parameter int COIL_BITS     = 32,
    parameter int MAX_READ      = 64
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_take,
    input  t_req i_req,
    output logic o_valid,
    input  wire  i_ready,
    output t_rsp o_rsp
);
    localparam int HW = $clog2(HOLDING_WORDS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_CLEAR = 5'b00010, S_RUN = 5'b00100,
        S_RD = 5'b01000, S_EMIT = 5'b10000
    } t_state;

    t_state      r_st;
    t_req        r_req;
    logic [15:0] r_mem [HOLDING_WORDS];
    logic [15:0] r_id;
    logic [HW-1:0] r_clr;
    logic [31:0] r_coil;
    logic [6:0]  r_n, r_cnt, r_i;
    logic [15:0] r_rdata;
    logic [15:0] r_raddr;
    logic        r_rvalid;
    t_rsp        r_out;
    logic        r_ov;

    logic        out_free;
    logic [15:0] st, qv, addr, waddr, wdata;
    logic        we;
    logic [31:0] src, cnext;
    logic [7:0]  byte_v;
    logic [15:0] pos, epos;
    logic [6:0]  nc;
    logic [6:0]  rd_i;
    logic [2:0]  k;
    logic        drop, rd_kind, emit, mem_we;

    assign out_free = !r_ov || i_ready;
    assign o_valid  = r_ov;
    assign o_rsp    = r_out;
    assign o_take   = (r_st == S_IDLE);
    assign st = r_req.start_register;
    assign qv = r_req.quantity_or_value;
    assign k  = r_req.kind;
    assign nc = (qv > 16'(MAX_READ)) ? 7'(MAX_READ) : qv[6:0];
    // read one word ahead when the current one is handed over this cycle
    assign rd_i = (r_st == S_RD && out_free) ? r_i + 7'd1 : r_i;
    assign addr = st + {9'd0, rd_i};
    assign drop = r_req.unit_address != 8'd0 && {8'd0, r_req.unit_address} != r_id;
    assign rd_kind = (k == K_RD_COILS) || (k == K_RD_INPUTS) || (k == K_RD_HOLD);
    assign emit = (r_st == S_RD || r_st == S_EMIT) && out_free;
    assign mem_we = (r_st == S_RUN) && out_free && we && !drop;

    // coil/input bit gather for one packed byte
    always_comb begin
        src = (k == K_RD_COILS) ? r_coil
                                : {{(32-PIN_BITS){1'b0}}, ~r_req.pin_levels};
        byte_v = '0;
        for (int j = 0; j < 8; j++) begin
            pos = st + {6'd0, r_i, 3'(j)} ;
            if ({6'd0, r_i, 3'(j)} < {9'd0, r_n}) begin
                if (k == K_RD_COILS) begin
                    if (pos < 16'(COIL_BITS)) byte_v[j] = src[pos[4:0]];
                end else if (pos < 16'(INPUT_BITS)) byte_v[j] = src[pos[4:0]];
            end
        end
    end

    // writes in S_RUN
    always_comb begin
        cnext = r_coil;
        we = 1'b0; waddr = st; wdata = qv;
        epos = '0;
        unique case (t_kind'(k))
            K_WR_COIL: if (st < 16'(COIL_BITS)) begin
                if (qv == 16'd0) cnext[st[4:0]] = 1'b0;
                else if (qv == COIL_ON) cnext[st[4:0]] = 1'b1;
            end
            K_COIL_ELEM: for (int j = 0; j < 8; j++) begin
                epos = st + {6'd0, r_req.element_index, 3'(j)};
                if ({6'd0, r_req.element_index, 3'(j)} < qv && epos < 16'(COIL_BITS))
                    cnext[epos[4:0]] = r_req.element_data[j];
            end
            K_WR_HOLD: begin
                we = (st < 16'(HOLDING_WORDS));
                wdata = is_swapped(st) ? {qv[7:0], qv[15:8]} : qv;
            end
            K_HOLD_ELEM: begin
                waddr = st + {9'd0, r_req.element_index};
                we = ({9'd0, r_req.element_index} < qv) && (waddr < 16'(HOLDING_WORDS));
                wdata = is_swapped(waddr) ? {r_req.element_data[7:0], r_req.element_data[15:8]}
                                          : r_req.element_data;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_CLEAR) r_mem[r_clr] <= '0;
        else if (mem_we) r_mem[waddr[HW-1:0]] <= wdata;
        r_rdata  <= r_mem[addr[HW-1:0]];
        r_raddr  <= addr;
        r_rvalid <= addr < 16'(HOLDING_WORDS);
        if (r_st == S_IDLE && i_valid) r_req <= i_req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLEAR; r_clr <= '0; r_coil <= '0; r_ov <= 1'b0;
            r_id <= '0; r_i <= '0; r_n <= '0; r_cnt <= '0;
        end else begin
            r_ov <= emit || (r_ov && !i_ready);
            unique case (r_st)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == HW'(HOLDING_WORDS - 1)) r_st <= S_IDLE;
                end
                S_IDLE: if (i_valid) begin
                    r_i <= '0;
                    r_st <= S_RUN;
                end
                // waits until a pending reply has left the output register
                S_RUN: if (out_free) begin
                    r_out.reply_channel <= r_req.source_channel;
                    r_out.reply_unit    <= r_id;
                    r_out.reply_kind    <= k;
                    r_out.echo_register <= rd_kind ? 16'd0 : st;
                    r_out.echo_quantity <= rd_kind ? 16'd0 : qv;
                    r_out.byte_count    <= '0;
                    r_out.data_value    <= '0;
                    r_out.data_index    <= '0;
                    r_out.last_result   <= 1'b1;
                    r_out.coil_drive    <= cnext[7:0];
                    r_n   <= nc;
                    r_cnt <= (k == K_RD_HOLD) ? nc : 7'((nc + 7'd7) >> 3);
                    if (drop)
                        r_st <= S_IDLE;
                    else begin
                        r_coil <= cnext;
                        if (we && waddr == 16'd0) r_id <= wdata;
                        priority if (k == K_IGNORED) r_st <= S_IDLE;
                        else if ((k == K_COIL_ELEM || k == K_HOLD_ELEM) && !r_req.last_element)
                            r_st <= S_IDLE;
                        else if (rd_kind)
                            r_st <= (nc == 7'd0) ? S_EMIT : S_RD;
                        else r_st <= S_EMIT;
                    end
                end
                S_RD: if (out_free) begin
                    r_out.data_index  <= r_i[5:0];
                    r_out.last_result <= (r_i + 7'd1 == r_cnt);
                    if (k == K_RD_HOLD) begin
                        r_out.byte_count <= {r_n, 1'b0};
                        r_out.data_value <= !r_rvalid ? 16'd0 :
                            is_swapped(r_raddr) ? {r_rdata[7:0], r_rdata[15:8]} : r_rdata;
                    end else begin
                        r_out.byte_count <= {1'b0, r_cnt};
                        r_out.data_value <= {8'd0, byte_v};
                    end
                    r_i <= r_i + 7'd1;
                    if (r_i + 7'd1 == r_cnt) r_st <= S_IDLE;
                end
                S_EMIT: if (out_free) begin
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/modbus_slave_register_engine_unit.sv -----
// Modbus slave register engine, top level: request queue front, executing back.
// Depends on msre_pkg, msre_if, msre_front, msre_back.
//
// Usage:
//  - i_req: one parsed request per transaction (valid/ready). A two-entry
//    queue decouples it from execution.
//  - o_rsp: reply transactions. Reads give one per packed byte (coils,
//    inputs) or per word (holding), writes give one acknowledge, element
//    items give one only on the last element. Dropped requests give none.
//  - Execution: S_IDLE, S_RUN, then S_RD per reply item or S_EMIT; the holding
//    word read port sets the one-item-per-cycle reply pace while o_rsp is ready.
//  - Reset: coils cleared, then a clearing pass over all HOLDING_WORDS words
//    zeroes the holding memory; requests queue but do not execute then.
//  - Receiver stall: the back end holds in place, the queue fills, then
//    ready drops.
`default_nettype none
module modbus_slave_register_engine_unit import msre_pkg::*; #(
    parameter int HOLDING_WORDS = 168,
    parameter int COIL_BITS     = 32,
    parameter int MAX_READ      = 64
) (
    input wire        i_clk,
    input wire        i_rst_n,
    msre_req_if.sink   i_req,
    msre_rsp_if.source o_rsp
);
    logic q_valid, q_take;
    t_req q_req;

    msre_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_req.valid), .o_ready(i_req.ready), .i_req(i_req.payload),
        .o_valid(q_valid), .i_take(q_take), .o_req(q_req)
    );

    msre_back #(.HOLDING_WORDS(HOLDING_WORDS), .COIL_BITS(COIL_BITS),
                .MAX_READ(MAX_READ)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_take(q_take), .i_req(q_req),
        .o_valid(o_rsp.valid), .i_ready(o_rsp.ready), .o_rsp(o_rsp.payload)
    );
endmodule
`default_nettype wire

// ----- rtl/core/msre_checker.sv -----
// Port-level checks for the register engine, bound to the top level.
// Depends on msre_pkg.
`default_nettype none
module msre_checker import msre_pkg::*; (
    input wire  i_clk,
    input wire  i_rst_n,
    input wire  rsp_valid,
    input wire  rsp_ready,
    input t_rsp rsp
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("reply dropped under stall");
    a_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && (rsp.reply_kind == K_WR_COIL || rsp.reply_kind == K_WR_HOLD)
        |-> rsp.last_result && rsp.byte_count == 8'd0)
        else $error("write acknowledge malformed");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> rsp.reply_kind != K_IGNORED)
        else $error("reply to ignored kind");
    a_hreg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp.reply_kind == K_RD_HOLD && rsp.byte_count != 8'd0
        |-> rsp.byte_count[0] == 1'b0)
        else $error("odd holding byte count");
endmodule

bind modbus_slave_register_engine_unit msre_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .rsp_valid(o_rsp.valid),
    .rsp_ready(o_rsp.ready), .rsp(o_rsp.payload)
);
`default_nettype wire

// ----- test/tb_top.sv -----
// Testbench for the Modbus slave register engine: directed and random requests,
// replies checked against a behavioral predictor. Depends on msre_pkg, msre_if, RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import msre_pkg::*;

    localparam int HOLD_N = 168;
    localparam int COIL_N = 32;
    localparam int RD_MAX = 64;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    msre_req_if req_ch ();
    msre_rsp_if rsp_ch ();

    modbus_slave_register_engine_unit i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    // Predictor state
    logic [31:0] coil_mirror;
    logic [15:0] hold_mirror [HOLD_N];
    t_rsp        reply_queue [$];
    int          fail_cnt;
    int          sent_cnt;
    int          reply_cnt;
    bit          no_idle;

    function automatic bit word_swapped(int w);
        if (w < 14) return w >= 3;
        return ((w - 14) % 22) >= 4;
    endfunction

    function automatic logic [15:0] swap_bytes(logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    function automatic void set_coil(int r, bit on);
        if (r < COIL_N) coil_mirror[r] = on;
    endfunction

    function automatic void push_reply(t_req q, logic [15:0] id, logic [15:0] ereg,
                                       logic [15:0] eq, logic [7:0] bc, logic [15:0] dv,
                                       logic [5:0] di, bit last);
        t_rsp r;
        r.reply_channel = q.source_channel;
        r.reply_unit    = id;
        r.reply_kind    = q.kind;
        r.echo_register = ereg;
        r.echo_quantity = eq;
        r.byte_count    = bc;
        r.data_value    = dv;
        r.data_index    = di;
        r.last_result   = last;
        r.coil_drive    = coil_mirror[7:0];
        reply_queue.push_back(r);
    endfunction

    function automatic void predict_request(t_req q);
        logic [15:0] id;
        logic [31:0] src;
        logic [15:0] rg;
        logic [15:0] v;
        int n, nb, lim, pos;
        logic [7:0] by;
        id = hold_mirror[0];
        if (q.unit_address != 0 && {8'd0, q.unit_address} != id) return;
        case (t_kind'(q.kind))
            K_RD_COILS, K_RD_INPUTS: begin
                src = (q.kind == K_RD_COILS) ? coil_mirror : {21'd0, ~q.pin_levels};
                lim = (q.kind == K_RD_COILS) ? COIL_N : INPUT_BITS;
                n = (q.quantity_or_value > RD_MAX) ? RD_MAX : q.quantity_or_value;
                nb = (n + 7) / 8;
                if (nb == 0) push_reply(q, id, 0, 0, 0, 0, 0, 1);
                for (int i = 0; i < nb; i++) begin
                    by = 0;
                    for (int j = 0; j < 8; j++) begin
                        pos = i * 8 + j;
                        if (pos < n) begin
                            rg = q.start_register + pos[15:0];
                            if (rg < lim && src[rg[4:0]]) by[j] = 1'b1;
                        end
                    end
                    push_reply(q, id, 0, 0, nb[7:0], {8'd0, by}, i[5:0], i + 1 == nb);
                end
            end
            K_WR_COIL: begin
                if (q.quantity_or_value == 0) set_coil(q.start_register, 0);
                else if (q.quantity_or_value == COIL_ON) set_coil(q.start_register, 1);
                push_reply(q, id, q.start_register, q.quantity_or_value, 0, 0, 0, 1);
            end
            K_COIL_ELEM: begin
                for (int j = 0; j < 8; j++) begin
                    pos = q.element_index * 8 + j;
                    if (pos < q.quantity_or_value) begin
                        rg = q.start_register + pos[15:0];
                        set_coil(rg, q.element_data[j]);
                    end
                end
                if (q.last_element)
                    push_reply(q, id, q.start_register, q.quantity_or_value, 0, 0, 0, 1);
            end
            K_RD_HOLD: begin
                n = (q.quantity_or_value > RD_MAX) ? RD_MAX : q.quantity_or_value;
                if (n == 0) push_reply(q, id, 0, 0, 0, 0, 0, 1);
                for (int i = 0; i < n; i++) begin
                    rg = q.start_register + i[15:0];
                    v = 0;
                    if (rg < HOLD_N) begin
                        v = hold_mirror[rg];
                        if (word_swapped(rg)) v = swap_bytes(v);
                    end
                    push_reply(q, id, 0, 0, 8'(2 * n), v, i[5:0], i + 1 == n);
                end
            end
            K_WR_HOLD: begin
                if (q.start_register < HOLD_N)
                    hold_mirror[q.start_register] = word_swapped(q.start_register) ?
                        swap_bytes(q.quantity_or_value) : q.quantity_or_value;
                push_reply(q, id, q.start_register, q.quantity_or_value, 0, 0, 0, 1);
            end
            K_HOLD_ELEM: begin
                if (q.element_index < q.quantity_or_value) begin
                    rg = q.start_register + q.element_index;
                    if (rg < HOLD_N)
                        hold_mirror[rg] = word_swapped(rg) ?
                            swap_bytes(q.element_data) : q.element_data;
                end
                if (q.last_element)
                    push_reply(q, id, q.start_register, q.quantity_or_value, 0, 0, 0, 1);
            end
            default: ;
        endcase
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 37);
    endfunction

    // Reply checker and receiver stalls
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready <= i_rst_n && !idle_now();
        end
    end

    always @(posedge i_clk) begin
        t_rsp got, want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            reply_cnt++;
            if (reply_queue.size() == 0) begin
                $error("unexpected reply transaction %p", got);
                fail_cnt++;
            end else begin
                want = reply_queue.pop_front();
                if (got.reply_channel !== want.reply_channel) begin
                    $error("reply_channel exp %0h got %0h", want.reply_channel,
                           got.reply_channel); fail_cnt++; end
                if (got.reply_unit !== want.reply_unit) begin
                    $error("reply_unit exp %0h got %0h", want.reply_unit,
                           got.reply_unit); fail_cnt++; end
                if (got.reply_kind !== want.reply_kind) begin
                    $error("reply_kind exp %0h got %0h", want.reply_kind,
                           got.reply_kind); fail_cnt++; end
                if (got.echo_register !== want.echo_register) begin
                    $error("echo_register exp %0h got %0h", want.echo_register,
                           got.echo_register); fail_cnt++; end
                if (got.echo_quantity !== want.echo_quantity) begin
                    $error("echo_quantity exp %0h got %0h", want.echo_quantity,
                           got.echo_quantity); fail_cnt++; end
                if (got.byte_count !== want.byte_count) begin
                    $error("byte_count exp %0h got %0h", want.byte_count,
                           got.byte_count); fail_cnt++; end
                if (got.data_value !== want.data_value) begin
                    $error("data_value exp %0h got %0h", want.data_value,
                           got.data_value); fail_cnt++; end
                if (got.data_index !== want.data_index) begin
                    $error("data_index exp %0h got %0h", want.data_index,
                           got.data_index); fail_cnt++; end
                if (got.last_result !== want.last_result) begin
                    $error("last_result exp %0h got %0h", want.last_result,
                           got.last_result); fail_cnt++; end
                if (got.coil_drive !== want.coil_drive) begin
                    $error("coil_drive exp %0h got %0h", want.coil_drive,
                           got.coil_drive); fail_cnt++; end
            end
        end
    end

    // Drive one request transaction; prediction at acceptance.
    // valid stays high after acceptance so back-to-back transactions need no gap.
    task automatic send_request(t_req q);
        while (idle_now()) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= q;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_request(q);
        sent_cnt++;
        @(negedge i_clk);
    endtask

    function automatic t_req make_req(t_kind k, logic [7:0] unit, logic [15:0] st,
                                      logic [15:0] qv);
        t_req q;
        q.kind              = k;
        q.unit_address      = unit;
        q.source_channel    = 8'($urandom);
        q.start_register    = st;
        q.quantity_or_value = qv;
        q.element_index     = 7'($urandom);
        q.element_data      = 16'($urandom);
        q.last_element      = 1'b0;
        q.pin_levels        = 11'($urandom);
        return q;
    endfunction

    task automatic test_directed();
        t_req q;
        send_request(make_req(K_RD_HOLD, 0, 0, 0));
        send_request(make_req(K_RD_COILS, 0, 0, 0));
        send_request(make_req(K_WR_COIL, 0, 3, COIL_ON));
        send_request(make_req(K_WR_COIL, 0, 31, COIL_ON));
        send_request(make_req(K_WR_COIL, 0, 3, 16'h1234));
        send_request(make_req(K_WR_COIL, 0, 40, COIL_ON));
        send_request(make_req(K_WR_COIL, 0, 3, 16'h0000));
        send_request(make_req(K_RD_COILS, 0, 16'hFFFC, 16'hFFFF));
        q = make_req(K_RD_INPUTS, 0, 0, 40);
        q.pin_levels = 11'h000;
        send_request(q);
        q = make_req(K_RD_INPUTS, 0, 16'hFFFF, 70);
        q.pin_levels = 11'h7FF;
        send_request(q);
        send_request(make_req(K_WR_HOLD, 0, 0, 16'h0042));
        send_request(make_req(K_WR_HOLD, 8'h42, 5, 16'hABCD));
        send_request(make_req(K_WR_HOLD, 8'h43, 5, 16'h1111));
        send_request(make_req(K_WR_HOLD, 0, 167, 16'hFFFF));
        send_request(make_req(K_WR_HOLD, 0, 168, 16'h5555));
        send_request(make_req(K_WR_HOLD, 0, 16'hFFFF, 16'h5555));
        send_request(make_req(K_RD_HOLD, 0, 16'hFFF0, 16'd100));
        send_request(make_req(K_RD_HOLD, 8'h42, 130, 16'd40));
        q = make_req(K_COIL_ELEM, 0, 30, 5);
        q.element_index = 0; q.element_data = 16'hFFFF; q.last_element = 1;
        send_request(q);
        q = make_req(K_HOLD_ELEM, 0, 10, 2);
        q.element_index = 0; q.element_data = 16'h00FF;
        send_request(q);
        q.element_index = 5; q.element_data = 16'hDEAD; q.last_element = 1;
        send_request(q);
        send_request(make_req(K_IGNORED, 0, 0, 1));
        send_request(make_req(K_WR_HOLD, 0, 0, 16'h0000));
        send_request(make_req(K_RD_HOLD, 0, 0, 16'd24));
    endtask

    function automatic logic [7:0] pick_unit();
        case ($urandom_range(3))
            0: return 8'($urandom);
            1: return hold_mirror[0][7:0];
            default: return 8'd0;
        endcase
    endfunction

    function automatic logic [15:0] pick_start();
        case ($urandom_range(4))
            0: return 16'($urandom);
            1: return 16'($urandom_range(32));
            2: return 16'hFFF0 + 16'($urandom_range(15));
            default: return 16'($urandom_range(175));
        endcase
    endfunction

    task automatic test_random(int cnt);
        t_req q;
        int qty;
        for (int i = 0; i < cnt; i++) begin
            q = make_req(t_kind'($urandom_range(7)), pick_unit(), pick_start(), 0);
            q.quantity_or_value = ($urandom_range(9) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(20));
            if (q.kind == K_WR_COIL && $urandom_range(1))
                q.quantity_or_value = $urandom_range(1) ? COIL_ON : 16'd0;
            if (q.kind == K_WR_HOLD || q.kind == K_WR_COIL)
                if ($urandom_range(3) == 0) q.quantity_or_value = 16'($urandom);
            q.last_element = 1'($urandom);
            if (q.kind == K_COIL_ELEM || q.kind == K_HOLD_ELEM) begin
                // well-formed multi-element sequence most of the time
                if ($urandom_range(3) != 0) begin
                    qty = $urandom_range(1, 12);
                    q.quantity_or_value = 16'(qty);
                    q.source_channel = 8'($urandom);
                    for (int e = 0; e <= qty; e++) begin
                        q.element_index = 7'(e);
                        q.element_data = 16'($urandom);
                        q.last_element = (e == qty) || (e == qty - 1 &&
                                          q.kind == K_HOLD_ELEM);
                        send_request(q);
                        if (q.last_element) break;
                    end
                    continue;
                end
            end
            send_request(q);
        end
    endtask

    initial begin
        int wait_cyc;
        fail_cnt = 0; sent_cnt = 0; reply_cnt = 0;
        no_idle = 0;
        coil_mirror = 0;
        foreach (hold_mirror[i]) hold_mirror[i] = 0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        no_idle = 1;
        test_random(15);
        no_idle = 0;
        test_random(30);
        req_ch.valid <= 1'b0;
        wait_cyc = 0;
        while (reply_queue.size() != 0 && wait_cyc < 20000) begin
            @(posedge i_clk);
            wait_cyc++;
        end
        repeat (200) @(posedge i_clk);
        $display("Covered %0d requests of every kind, %0d replies checked.", sent_cnt,
                 reply_cnt);
        if (fail_cnt == 0 && reply_queue.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/msre_pkg.sv
rtl/core/msre_if.sv
rtl/core/msre_front.sv
rtl/core/msre_back.sv
rtl/core/modbus_slave_register_engine_unit.sv
rtl/core/msre_checker.sv
test/tb_top.sv
